FILE: hdl/tilt_joystick_mapper_top_assert.svh
// ----------------------------------------------------------------------------
// Tilt joystick mapper assertion macros
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TILT_JOYSTICK_MAPPER_TOP_ASSERT_SVH
`define TILT_JOYSTICK_MAPPER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TJM_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TJM_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

// Next-cycle implication, active during reset as well.
`define TJM_ASSERT_NEXT_ALWAYS(label, clk, cond, prop, msg) \
    label: assert property (@(posedge clk) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: hdl/tjm_pkg.sv
// ----------------------------------------------------------------------------
// Tilt joystick mapper package
// Types, widths, CORDIC angle table and scaling constants.
// ----------------------------------------------------------------------------
package tjm_pkg;

    localparam int FIELD_W   = 16;
    localparam int VEC_W     = 27;
    localparam int ACC_W     = 25;
    localparam int RAW_W     = 18;
    localparam int STICK_W   = 17;
    localparam int NUM_W     = 25;
    localparam int QUOT_W    = 21;
    localparam int CFG_ADDR_W = 1;

    localparam int ATAN_DEPTH = 24;

    // atan(2^-i) in degrees times 65536
    localparam logic signed [ACC_W-1:0] ATAN_TABLE [0:ATAN_DEPTH-1] = '{
        25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
        25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
        25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
        25'sd917,     25'sd458,     25'sd229,    25'sd115,
        25'sd57,      25'sd29,      25'sd14,     25'sd7,
        25'sd4,       25'sd2,       25'sd1,      25'sd0
    };

    localparam logic [CFG_ADDR_W-1:0] CFG_ALPHA_OFFSET = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BETA_OFFSET  = 1'd1;

    localparam logic signed [18:0] ANGLE_LIMIT = 19'sd92160;
    localparam logic [STICK_W-1:0] STICK_MID   = 17'd51200;
    localparam logic [STICK_W-1:0] STICK_MAX   = 17'd102400;
    localparam logic [STICK_W-1:0] DEAD_LOW    = 17'd49152;
    localparam logic [STICK_W-1:0] DEAD_HIGH   = 17'd53248;

    // n' = 100 * d + 9 + 18 * 700000 stays positive and below 2^25
    localparam logic signed [26:0] NUM_BIAS    = 27'sd12600009;
    localparam logic [25:0]        DIV_RECIP   = 26'd59652323;
    localparam int                 DIV_SHIFT   = 30;
    localparam logic [4:0]         DIV_BASE    = 5'd18;
    localparam logic signed [21:0] STICK_BIAS  = 22'sd648800;

    typedef struct packed {
        logic signed [VEC_W-1:0] vx;
        logic signed [VEC_W-1:0] vy;
        logic signed [ACC_W-1:0] acc;
        logic                    zero_num;
        logic                    zero_den;
        logic                    num_pos;
    } lane_t;

    typedef struct packed {
        lane_t beta;
        lane_t alpha;
    } cordic_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] beta_offset;
        logic signed [FIELD_W-1:0] alpha_offset;
    } cfg_t;

    typedef struct packed {
        logic [STICK_W-1:0]      stick_beta;
        logic [STICK_W-1:0]      stick_alpha;
        logic signed [RAW_W-1:0] raw_beta;
        logic signed [RAW_W-1:0] raw_alpha;
    } result_t;

endpackage

FILE: hdl/tjm_fold.sv
// ----------------------------------------------------------------------------
// Tilt joystick mapper input fold
// Folds the sample to non-negative z and loads the CORDIC vectors.
// ----------------------------------------------------------------------------
module tjm_fold (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [tjm_pkg::FIELD_W-1:0] field_x,
    input  logic signed [tjm_pkg::FIELD_W-1:0] field_y,
    input  logic signed [tjm_pkg::FIELD_W-1:0] field_z,
    output logic                               out_valid,
    input  logic                               out_ready,
    output tjm_pkg::cordic_t                   out_data
);
    import tjm_pkg::*;

    logic            valid_reg;
    cordic_t         data_reg;
    cordic_t         data_next;
    logic signed [FIELD_W-1:0] fx, fy, fz;

    function automatic logic signed [FIELD_W-1:0] neg_sat(input logic signed [FIELD_W-1:0] v);
        logic signed [FIELD_W-1:0] r;
        if (v == {1'b1, {(FIELD_W-1){1'b0}}}) begin
            r = {1'b0, {(FIELD_W-1){1'b1}}};
        end else begin
            r = -v;
        end
        return r;
    endfunction

    function automatic lane_t load_lane(input logic signed [FIELD_W-1:0] num,
                                        input logic signed [FIELD_W-1:0] den);
        lane_t l;
        l.vx       = {{(VEC_W-FIELD_W-8){den[FIELD_W-1]}}, den, 8'd0};
        l.vy       = {{(VEC_W-FIELD_W-8){num[FIELD_W-1]}}, num, 8'd0};
        l.acc      = '0;
        l.zero_num = (num == '0);
        l.zero_den = (den == '0);
        l.num_pos  = !num[FIELD_W-1] && (num != '0);
        return l;
    endfunction

    always_comb begin
        if (field_z[FIELD_W-1]) begin
            fx = neg_sat(field_x);
            fy = neg_sat(field_y);
            fz = neg_sat(field_z);
        end else begin
            fx = field_x;
            fy = field_y;
            fz = field_z;
        end
        data_next.alpha = load_lane(fx, fz);
        data_next.beta  = load_lane(fy, fz);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: hdl/tjm_cordic_stage.sv
// ----------------------------------------------------------------------------
// Tilt joystick mapper CORDIC stage
// One registered vectoring iteration for both tilt lanes.
// ----------------------------------------------------------------------------
module tjm_cordic_stage #(
    parameter int STAGE = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  tjm_pkg::cordic_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output tjm_pkg::cordic_t out_data
);
    import tjm_pkg::*;

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;

    function automatic lane_t rotate(input lane_t l);
        lane_t r;
        logic signed [VEC_W-1:0] sx;
        logic signed [VEC_W-1:0] sy;
        r  = l;
        sx = l.vx >>> STAGE;
        sy = l.vy >>> STAGE;
        if (l.vy > 0) begin
            r.vx  = l.vx + sy;
            r.vy  = l.vy - sx;
            r.acc = l.acc + ATAN_TABLE[STAGE];
        end else begin
            r.vx  = l.vx - sy;
            r.vy  = l.vy + sx;
            r.acc = l.acc - ATAN_TABLE[STAGE];
        end
        return r;
    endfunction

    always_comb begin
        data_next.alpha = rotate(in_data.alpha);
        data_next.beta  = rotate(in_data.beta);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: hdl/tjm_post.sv
// ----------------------------------------------------------------------------
// Tilt joystick mapper post-processing
// Angle rounding, offset, 50/9 scaling, clamp and dead zone in five stages.
// ----------------------------------------------------------------------------
module tjm_post (
    input  logic             aclk,
    input  logic             aresetn,
    input  tjm_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  tjm_pkg::cordic_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output tjm_pkg::result_t out_data
);
    import tjm_pkg::*;

    localparam int NSTG = 5;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] en;

    logic signed [RAW_W-1:0]   raw1_reg [2];
    logic signed [RAW_W-1:0]   raw2_reg [2];
    logic signed [RAW_W-1:0]   raw3_reg [2];
    logic signed [RAW_W-1:0]   raw4_reg [2];
    logic [NUM_W-1:0]          num2_reg [2];
    logic [NUM_W-1:0]          num3_reg [2];
    logic [QUOT_W-1:0]         quot3_reg [2];
    logic [STICK_W-1:0]        stick4_reg [2];
    result_t                   res_reg;

    logic signed [RAW_W-1:0]   raw1_next [2];
    logic [NUM_W-1:0]          num2_next [2];
    logic [QUOT_W-1:0]         quot3_next [2];
    logic [STICK_W-1:0]        stick4_next [2];
    result_t                   res_next;
    logic signed [FIELD_W-1:0] offs [2];
    lane_t                     lanes [2];

    function automatic logic signed [RAW_W-1:0] round_angle(input lane_t l);
        logic signed [ACC_W-1:0] rsum;
        logic signed [18:0]      rnd;
        logic signed [18:0]      r;
        rsum = l.acc + 25'sd32;
        rnd  = rsum[ACC_W-1:6];
        if (l.zero_num) begin
            r = '0;
        end else if (l.zero_den) begin
            r = l.num_pos ? ANGLE_LIMIT : -ANGLE_LIMIT;
        end else if (rnd > ANGLE_LIMIT) begin
            r = ANGLE_LIMIT;
        end else if (rnd < -ANGLE_LIMIT) begin
            r = -ANGLE_LIMIT;
        end else begin
            r = rnd;
        end
        return r[RAW_W-1:0];
    endfunction

    function automatic logic [NUM_W-1:0] scale_num(input logic signed [RAW_W-1:0] raw,
                                                   input logic signed [FIELD_W-1:0] off);
        logic signed [18:0] d;
        logic signed [26:0] n;
        d = {raw[RAW_W-1], raw} - {{3{off[FIELD_W-1]}}, off};
        n = {{8{d[18]}}, d} * 27'sd100 + NUM_BIAS;
        return n[NUM_W-1:0];
    endfunction

    function automatic logic [QUOT_W-1:0] quot_est(input logic [NUM_W-1:0] n);
        logic [50:0] p;
        p = 51'(n) * 51'(DIV_RECIP);
        return p[DIV_SHIFT+QUOT_W-1:DIV_SHIFT];
    endfunction

    function automatic logic [STICK_W-1:0] finish(input logic [NUM_W-1:0] n,
                                                  input logic [QUOT_W-1:0] est);
        logic [25:0]        rem;
        logic [QUOT_W-1:0]  q;
        logic signed [21:0] s;
        logic [STICK_W-1:0] r;
        rem = {1'b0, n} - (26'(est) * 26'(DIV_BASE));
        q   = est + QUOT_W'(rem >= 26'(DIV_BASE));
        s   = $signed({1'b0, q}) - STICK_BIAS;
        if (s < 0) begin
            r = '0;
        end else if (s > $signed({5'd0, STICK_MAX})) begin
            r = STICK_MAX;
        end else begin
            r = s[STICK_W-1:0];
        end
        return r;
    endfunction

    assign lanes[0] = in_data.alpha;
    assign lanes[1] = in_data.beta;
    assign offs[0]  = cfg.alpha_offset;
    assign offs[1]  = cfg.beta_offset;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            raw1_next[k]   = round_angle(lanes[k]);
            num2_next[k]   = scale_num(raw1_reg[k], offs[k]);
            quot3_next[k]  = quot_est(num2_reg[k]);
            stick4_next[k] = finish(num3_reg[k], quot3_reg[k]);
        end
        res_next.raw_alpha = raw4_reg[0];
        res_next.raw_beta  = raw4_reg[1];
        if (stick4_reg[0] > DEAD_LOW && stick4_reg[0] < DEAD_HIGH &&
            stick4_reg[1] > DEAD_LOW && stick4_reg[1] < DEAD_HIGH) begin
            res_next.stick_alpha = STICK_MID;
            res_next.stick_beta  = STICK_MID;
        end else begin
            res_next.stick_alpha = stick4_reg[0];
            res_next.stick_beta  = stick4_reg[1];
        end
    end

    always_comb begin
        en[NSTG-1] = !valid_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0] && in_valid) begin
            raw1_reg <= raw1_next;
        end
        if (en[1] && valid_reg[0]) begin
            raw2_reg <= raw1_reg;
            num2_reg <= num2_next;
        end
        if (en[2] && valid_reg[1]) begin
            raw3_reg  <= raw2_reg;
            num3_reg  <= num2_reg;
            quot3_reg <= quot3_next;
        end
        if (en[3] && valid_reg[2]) begin
            raw4_reg   <= raw3_reg;
            stick4_reg <= stick4_next;
        end
        if (en[4] && valid_reg[3]) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg[NSTG-1];
    assign out_data  = res_reg;

endmodule

FILE: hdl/tilt_joystick_mapper_top.sv
// ----------------------------------------------------------------------------
// Tilt joystick mapper
// Maps a magnetometer sample to two tilt angles and joystick positions.
//
// Input stream s_*: one magnetometer sample (x, y, z) per transaction.
// Output stream m_*: raw tilt angles and stick positions, one transaction
// per input transaction, in order.
// Configuration: cfg_we writes cfg_wdata into the offset selected by
// cfg_addr (0 alpha, 1 beta); write only while no transaction is in flight.
// The pipeline holds one fold stage, one register per CORDIC iteration,
// and five stages for rounding, offset, the 50/9 reciprocal multiply,
// its correction and clamp, and the dead zone.
// Throughput is one transaction per cycle while m_tready stays high,
// set by the fully unrolled CORDIC pipeline.
// Every stage carries its own valid bit and advances when empty or when
// the next stage advances, so bubbles collapse while m_tready is low and
// s_tready drops only once all stages hold data.
// Reset clears the valid bits and both offsets to zero.
// ----------------------------------------------------------------------------
module tilt_joystick_mapper_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // field_x [15:0], field_y [31:16], field_z [47:32]
    input  logic [47:0]                         s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // raw_alpha [17:0], raw_beta [35:18], stick_alpha [52:36],
    // stick_beta [69:53], zero [71:70]
    output logic [71:0]                         m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_we,
    input  logic [tjm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [tjm_pkg::FIELD_W-1:0]         cfg_wdata
);
    import tjm_pkg::*;

    logic signed [FIELD_W-1:0] alpha_offset_reg;
    logic signed [FIELD_W-1:0] beta_offset_reg;
    cfg_t                      cfg;

    cordic_t stg_data  [CORDIC_STAGES+1];
    logic    stg_valid [CORDIC_STAGES+1];
    logic    stg_ready [CORDIC_STAGES+1];
    result_t res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_offset_reg <= '0;
            beta_offset_reg  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_ALPHA_OFFSET: alpha_offset_reg <= $signed(cfg_wdata);
                CFG_BETA_OFFSET:  beta_offset_reg  <= $signed(cfg_wdata);
            endcase
        end
    end

    assign cfg.alpha_offset = alpha_offset_reg;
    assign cfg.beta_offset  = beta_offset_reg;

    tjm_fold u_fold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .field_x   ($signed(s_tdata[15:0])),
        .field_y   ($signed(s_tdata[31:16])),
        .field_z   ($signed(s_tdata[47:32])),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_data  (stg_data[0])
    );

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        tjm_cordic_stage #(
            .STAGE (k)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[k]),
            .in_ready  (stg_ready[k]),
            .in_data   (stg_data[k]),
            .out_valid (stg_valid[k+1]),
            .out_ready (stg_ready[k+1]),
            .out_data  (stg_data[k+1])
        );
    end

    tjm_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (stg_valid[CORDIC_STAGES]),
        .in_ready  (stg_ready[CORDIC_STAGES]),
        .in_data   (stg_data[CORDIC_STAGES]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {2'b00, res};

endmodule

FILE: hdl/tjm_sva.sv
// ----------------------------------------------------------------------------
// Tilt joystick mapper port checker
// Output ranges, dead zone, reset and stall behavior seen at the ports.
// ----------------------------------------------------------------------------
`include "tilt_joystick_mapper_top_assert.svh"

module tjm_sva (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);
    logic [16:0]        sa;
    logic [16:0]        sb;
    logic signed [17:0] ra;
    logic signed [17:0] rb;
    logic               stick_ok;
    logic               raw_ok;
    logic               in_band;
    logic               centered;
    logic               stalled;
    logic [72:0]        m_bus;

    assign ra       = $signed(m_tdata[17:0]);
    assign rb       = $signed(m_tdata[35:18]);
    assign sa       = m_tdata[52:36];
    assign sb       = m_tdata[69:53];
    assign stick_ok = sa <= 17'd102400 && sb <= 17'd102400 && m_tdata[71:70] == 2'b00;
    assign raw_ok   = ra >= -18'sd92160 && ra <= 18'sd92160 &&
                      rb >= -18'sd92160 && rb <= 18'sd92160;
    assign in_band  = m_tvalid && sa > 17'd49152 && sa < 17'd53248 &&
                      sb > 17'd49152 && sb < 17'd53248;
    assign centered = sa == 17'd51200 && sb == 17'd51200;
    assign stalled  = m_tvalid && !m_tready;
    assign m_bus    = {m_tvalid, m_tdata};

    `TJM_ASSERT_NEXT_ALWAYS(a_reset_clears, aclk, !aresetn, !m_tvalid, "output valid after reset")

    `TJM_ASSERT_IMPLY(a_stick_range, aclk, aresetn, m_tvalid, stick_ok, "stick out of range")

    `TJM_ASSERT_IMPLY(a_raw_range, aclk, aresetn, m_tvalid, raw_ok, "raw angle out of range")

    `TJM_ASSERT_IMPLY(a_dead_zone, aclk, aresetn, in_band, centered, "dead zone not applied")

    `TJM_ASSERT_NEXT(a_stall_hold, aclk, aresetn, stalled, $stable(m_bus), "held output changed")

endmodule

bind tilt_joystick_mapper_top tjm_sva u_tjm_sva (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
